// ===== rtl/brsa_pkg.sv =====
// Package for the bitmap run slot allocator: word geometry, request and status
// codes, reserved-slot constants and the structs shared by the map memory, the
// word scanner and the top level. No dependencies.
package brsa_pkg;

  localparam int WORD_BITS      = 32;
  localparam int POS_W          = 5;   // bit position inside one map word
  localparam int CNT_W          = 6;   // slot count of a run, 1..WORD_BITS
  localparam int SLOT_W         = 7;   // width of a slot index on the ports
  localparam int SIZE_W         = 16;
  localparam int MAP_WORDS_DEF  = 4;
  localparam int SLOT_BYTES_DEF = 32;

  // Request codes on the func port.
  localparam logic FN_ALLOC = 1'b0;
  localparam logic FN_FREE  = 1'b1;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_NOSPACE = 2'd1;
  localparam logic [1:0] ST_BADSIZE = 2'd2;
  localparam logic [1:0] ST_BADFREE = 2'd3;

  localparam logic [WORD_BITS-1:0] RESERVED_MASK = 32'h0000_000f;
  localparam logic [WORD_BITS-1:0] RESERVED_HEAD = 32'h0000_0001;
  localparam logic [WORD_BITS-1:0] FULL_WORD     = 32'hffff_ffff;

  // One entry of the map memory: header bits and used bits of one word.
  typedef struct packed {
    logic [WORD_BITS-1:0] header;
    logic [WORD_BITS-1:0] used;
  } map_word_t;

  // What the word scanner reports about the word under test.
  typedef struct packed {
    logic             fit;
    logic [POS_W-1:0] fit_pos;
    map_word_t        alloc_word;
    logic             free_ok;
    map_word_t        free_word;
  } scan_res_t;

endpackage

// ===== rtl/brsa_map_mem.sv =====
// Map memory of the slot allocator: one entry per map word holding both
// bitmaps, with a registered read port and one write port.
// Depends on brsa_pkg.
module brsa_map_mem #(
  parameter int MAP_WORDS = brsa_pkg::MAP_WORDS_DEF,
  parameter int AW        = 2
) (
  input  logic                clk,
  input  logic                rst,
  input  logic [AW-1:0]       addr,
  input  logic                wr_en,
  input  brsa_pkg::map_word_t wdata,
  output brsa_pkg::map_word_t rdata
);

  brsa_pkg::map_word_t mem [MAP_WORDS];
  logic [MAP_WORDS-1:0] valid;
  brsa_pkg::map_word_t  init_word;

  // An entry never written reads as its reset contents.
  always_comb begin
    init_word = '0;
    if (addr == '0) begin
      init_word.header = brsa_pkg::RESERVED_HEAD;
      init_word.used   = brsa_pkg::RESERVED_MASK;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[addr] <= wdata;
    end
    rdata <= valid[addr] ? mem[addr] : init_word;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else if (wr_en) begin
      valid[addr] <= 1'b1;
    end
  end

endmodule

// ===== rtl/brsa_div.sv =====
// Slot count unit: rounds a byte count up to whole slots by comparing it with
// every whole multiple of the slot size at once, registered when load is high.
// Depends on brsa_pkg.
module brsa_div #(
  parameter int SLOT_BYTES = brsa_pkg::SLOT_BYTES_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       load,
  input  logic [brsa_pkg::SIZE_W-1:0] size,
  output logic                       done,
  output logic [brsa_pkg::CNT_W-1:0] count
);

  // Bit k is set when the byte count needs more than k slots.
  logic [brsa_pkg::WORD_BITS-1:0] exceeds;
  logic [brsa_pkg::CNT_W-1:0]     count_next;

  always_comb begin
    exceeds = '0;
    for (int k = 1; k < brsa_pkg::WORD_BITS; k++) begin
      exceeds[k] = (32'(size) > 32'(k * SLOT_BYTES));
    end
    count_next = brsa_pkg::CNT_W'($countones(exceeds) + 1);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= load;
    end
    if (load) begin
      count <= count_next;
    end
  end

endmodule

// ===== rtl/brsa_scan.sv =====
// Word scanner: finds the lowest free window of a run length inside one map
// word and works out the cleared word for a free from a header bit.
// Depends on brsa_pkg.
module brsa_scan (
  input  brsa_pkg::map_word_t          word,
  input  logic [brsa_pkg::CNT_W-1:0]   n,
  input  logic [brsa_pkg::POS_W-1:0]   b,
  output brsa_pkg::scan_res_t          res
);

  logic [brsa_pkg::WORD_BITS-1:0]   run_m;
  logic [brsa_pkg::WORD_BITS-1:0]   fits;
  logic [2*brsa_pkg::WORD_BITS-1:0] win;
  logic [brsa_pkg::WORD_BITS-1:0]   stop;
  logic [brsa_pkg::WORD_BITS-1:0]   above;
  logic [brsa_pkg::WORD_BITS-1:0]   s;
  logic [brsa_pkg::WORD_BITS-1:0]   upto;
  logic [brsa_pkg::WORD_BITS-1:0]   clr;

  always_comb begin
    run_m = brsa_pkg::FULL_WORD >> (brsa_pkg::CNT_W'(brsa_pkg::WORD_BITS) - n);
    for (int t = 0; t < brsa_pkg::WORD_BITS; t++) begin
      win     = (2*brsa_pkg::WORD_BITS)'(run_m) << t;
      fits[t] = ((win[brsa_pkg::WORD_BITS-1:0] & word.used) == '0) &&
                (win[2*brsa_pkg::WORD_BITS-1:brsa_pkg::WORD_BITS] == '0);
    end
    res.fit     = |fits;
    res.fit_pos = '0;
    for (int t = brsa_pkg::WORD_BITS - 1; t >= 0; t--) begin
      if (fits[t]) begin
        res.fit_pos = brsa_pkg::POS_W'(t);
      end
    end
    res.alloc_word.used   = word.used | (run_m << res.fit_pos);
    res.alloc_word.header = word.header |
                            (brsa_pkg::WORD_BITS'(1) << res.fit_pos);

    // A run ends before the first slot above b that is a header or unused.
    stop  = word.header | ~word.used;
    above = brsa_pkg::WORD_BITS'({1'b1, brsa_pkg::FULL_WORD} <<
                                 ({1'b0, b} + 6'd1));
    s     = stop & above;
    upto  = (s == '0) ? brsa_pkg::FULL_WORD : ((s & (~s + 1'b1)) - 1'b1);
    clr   = upto & (brsa_pkg::FULL_WORD << b);
    res.free_ok          = word.used[b] && word.header[b];
    res.free_word.used   = word.used & ~clr;
    res.free_word.header = word.header & ~clr;
  end

endmodule

// ===== rtl/bitmap_run_slot_allocator_unit.sv =====
// Top level of the bitmap run slot allocator: request sequencer and result
// registers. Depends on brsa_pkg, brsa_map_mem, brsa_div and brsa_scan.
//
// A request is taken when start is high and busy is low. Its single result
// appears on status and granted_slot for exactly one cycle with done high;
// the receiver cannot stall, so it must capture the result in that cycle.
// An allocate first rounds size_bytes up to whole slots in the slot count
// unit, which compares it with every multiple of the slot size at once and
// registers the count, then tests the map words one at a time, each with a
// memory read and a scan of the whole word. A free reads the map word of its
// slot and then evaluates it. A request refused on its fields alone (zero or
// oversize size, a slot beyond the map or a reserved slot) answers in the
// cycle after it is taken, and busy stays low. Slots 0 to 3 are reserved from
// reset; the map memory needs no clearing pass.
module bitmap_run_slot_allocator_unit #(
  parameter int MAP_WORDS  = brsa_pkg::MAP_WORDS_DEF,
  parameter int SLOT_BYTES = brsa_pkg::SLOT_BYTES_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  output logic                         busy,
  input  logic                         func,
  input  logic [brsa_pkg::SIZE_W-1:0]  size_bytes,
  input  logic [brsa_pkg::SLOT_W-1:0]  slot_index,
  output logic                         done,
  output logic [1:0]                   status,
  output logic [brsa_pkg::SLOT_W-1:0]  granted_slot
);

  localparam int AW        = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
  localparam int MAX_BYTES = brsa_pkg::WORD_BITS * SLOT_BYTES;

  typedef enum logic [2:0] {S_IDLE, S_DIV, S_RD, S_EV, S_FEV} state_t;

  state_t                      state;
  logic                        func_r;
  logic [brsa_pkg::POS_W-1:0]  b_r;
  logic [AW-1:0]               addr;

  logic                        accept;
  logic                        size_bad;
  logic                        free_bad;
  logic                        div_load;
  logic                        div_done;
  logic [brsa_pkg::CNT_W-1:0]  n;
  logic                        wr_en;
  brsa_pkg::map_word_t         wdata;
  brsa_pkg::map_word_t         rdata;
  brsa_pkg::scan_res_t         res;
  logic [1:0]                  word_in;

  assign busy     = (state != S_IDLE);
  assign accept   = start && !busy;
  assign word_in  = slot_index[brsa_pkg::SLOT_W-1:brsa_pkg::POS_W];
  assign size_bad = (size_bytes == '0) || (32'(size_bytes) > MAX_BYTES);
  assign free_bad = (32'(word_in) >= MAP_WORDS) ||
                    ((word_in == 2'd0) &&
                     brsa_pkg::RESERVED_MASK[slot_index[brsa_pkg::POS_W-1:0]]);
  assign div_load = accept && (func == brsa_pkg::FN_ALLOC) && !size_bad;

  brsa_div #(.SLOT_BYTES(SLOT_BYTES)) u_div (
    .clk   (clk),
    .rst   (rst),
    .load  (div_load),
    .size  (size_bytes),
    .done  (div_done),
    .count (n)
  );

  brsa_map_mem #(.MAP_WORDS(MAP_WORDS), .AW(AW)) u_mem (
    .clk   (clk),
    .rst   (rst),
    .addr  (addr),
    .wr_en (wr_en),
    .wdata (wdata),
    .rdata (rdata)
  );

  brsa_scan u_scan (
    .word (rdata),
    .n    (n),
    .b    (b_r),
    .res  (res)
  );

  // The map word is written back in the evaluate cycle that succeeds.
  always_comb begin
    wr_en = 1'b0;
    wdata = res.alloc_word;
    if (state == S_EV && res.fit) begin
      wr_en = 1'b1;
    end else if (state == S_FEV && res.free_ok) begin
      wr_en = 1'b1;
      wdata = res.free_word;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      done         <= 1'b0;
      status       <= brsa_pkg::ST_OK;
      granted_slot <= '0;
      addr         <= '0;
    end else begin
      done <= 1'b0;
      case (state)
        S_IDLE: begin
          if (accept) begin
            func_r       <= func;
            b_r          <= slot_index[brsa_pkg::POS_W-1:0];
            granted_slot <= '0;
            if (func == brsa_pkg::FN_ALLOC) begin
              if (size_bad) begin
                done   <= 1'b1;
                status <= brsa_pkg::ST_BADSIZE;
              end else begin
                state <= S_DIV;
              end
            end else begin
              if (free_bad) begin
                done   <= 1'b1;
                status <= brsa_pkg::ST_BADFREE;
              end else begin
                addr  <= AW'(word_in);
                state <= S_RD;
              end
            end
          end
        end
        S_DIV: begin
          if (div_done) begin
            addr  <= '0;
            state <= S_RD;
          end
        end
        S_RD: begin
          // The map word at addr is registered out of the memory here.
          state <= (func_r == brsa_pkg::FN_FREE) ? S_FEV : S_EV;
        end
        S_EV: begin
          if (res.fit) begin
            done         <= 1'b1;
            status       <= brsa_pkg::ST_OK;
            granted_slot <= brsa_pkg::SLOT_W'({addr, res.fit_pos});
            state        <= S_IDLE;
          end else if (addr == AW'(MAP_WORDS - 1)) begin
            done   <= 1'b1;
            status <= brsa_pkg::ST_NOSPACE;
            state  <= S_IDLE;
          end else begin
            addr  <= addr + 1'b1;
            state <= S_RD;
          end
        end
        S_FEV: begin
          done   <= 1'b1;
          status <= res.free_ok ? brsa_pkg::ST_OK : brsa_pkg::ST_BADFREE;
          state  <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // A result follows either a request taken in the previous cycle or work
  // that was in progress.
  a_done_cause: assert property (@(posedge clk) disable iff (rst)
    done |-> ($past(start && !busy) || $past(busy)))
    else $error("result without a request");

  // A failed request never carries a slot number.
  a_fail_zero: assert property (@(posedge clk) disable iff (rst)
    (done && status != brsa_pkg::ST_OK) |-> (granted_slot == '0))
    else $error("slot reported on a failed request");

  // The maps change only in an evaluate cycle.
  a_write_state: assert property (@(posedge clk) disable iff (rst)
    wr_en |-> (state == S_EV || state == S_FEV))
    else $error("map written outside evaluation");

  // Every evaluation sees a word read in the cycle before.
  a_read_first: assert property (@(posedge clk) disable iff (rst)
    (state == S_EV || state == S_FEV) |-> ($past(state) == S_RD))
    else $error("word evaluated without a read");

endmodule
